### hdl/mgte_pkg.sv
// Package for the MIDI to gate/trigger engine.
// Holds field widths, MIDI byte codes, configuration indexes and reset values.
// No dependencies.
package mgte_pkg;

  // Field widths
  localparam int GATE_W  = 8;
  localparam int CVIDX_W = 3;
  localparam int CVVAL_W = 7;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 32;

  // Voice message types (high nibble of a status byte)
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CC       = 4'hB;

  // Realtime bytes
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONTINUE = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;
  localparam logic [4:0] RT_PREFIX   = 5'b11111;

  // Controllers that silence every note-sourced gate that is not in trigger mode
  localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

  // Parser states
  localparam logic [1:0] PARSE_IDLE   = 2'd0;
  localparam logic [1:0] PARSE_STATUS = 2'd1;
  localparam logic [1:0] PARSE_DATA1  = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LISTEN_CHANNEL = 3'd0,
    CFG_TRIGGER_LENGTH = 3'd1,
    CFG_TRIGGER_MODE   = 3'd2,
    CFG_NOTE_SOURCE    = 3'd3,
    CFG_GATE_PARAM_LO  = 3'd4,
    CFG_GATE_PARAM_HI  = 3'd5,
    CFG_CV_MAP_LO      = 3'd6,
    CFG_CV_MAP_HI      = 3'd7
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [3:0]  RST_LISTEN_CHANNEL = 4'd9;
  localparam logic [7:0]  RST_TRIGGER_LENGTH = 8'd10;
  localparam logic [7:0]  RST_TRIGGER_MODE   = 8'hBF;
  localparam logic [7:0]  RST_NOTE_SOURCE    = 8'h0F;
  localparam logic [31:0] RST_GATE_PARAM_LO  = 32'h2E2A_2624;
  localparam logic [31:0] RST_GATE_PARAM_HI  = 32'h0000_1810;
  localparam logic [31:0] RST_CV_MAP_LO      = 32'h2E2A_2624;
  localparam logic [31:0] RST_CV_MAP_HI      = 32'hD2BF_9D98;

endpackage

### hdl/mgte_in_if.sv
// Input channel interface: one MIDI byte or one millisecond tick per transaction.
// Depends on mgte_pkg.
interface mgte_in_if;
  import mgte_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] received_byte;

  modport source (output valid, output mode, output received_byte, input ready);
  modport sink   (input valid, input mode, input received_byte, output ready);
endinterface

### hdl/mgte_out_if.sv
// Result channel interface: gate levels and an optional CV update per transaction.
// Depends on mgte_pkg.
interface mgte_out_if;
  import mgte_pkg::*;

  logic               valid;
  logic               ready;
  logic [GATE_W-1:0]  gate_levels;
  logic               cv_valid;
  logic [CVIDX_W-1:0] cv_index;
  logic [CVVAL_W-1:0] cv_value;
  logic               last;

  modport source (output valid, output gate_levels, output cv_valid, output cv_index,
                  output cv_value, output last, input ready);
  modport sink   (input valid, input gate_levels, input cv_valid, input cv_index,
                  input cv_value, input last, output ready);
endinterface

### hdl/midi_to_gate_trigger_engine.sv
// Top level of the MIDI to gate/trigger engine: parser, gate logic and result queue.
// Depends on mgte_pkg, mgte_in_if and mgte_out_if.
//
// Usage:
//   in_ch carries one transaction per MIDI byte (mode 0) or per millisecond
//   tick (mode 1). out_ch returns, for each input, one result per matching
//   CV slot in slot order, or a single result with cv_valid low; last marks
//   the final result of an input. gate_levels is the level after the input.
//   cfg_we/cfg_index/cfg_data write one configuration register per cycle;
//   write only while no results are pending.
// Timing:
//   The state update happens at the input transaction; its first result is
//   presented on the next cycle. An input with k CV updates gives max(1, k)
//   results from the single result register, which shifts out one CV slot
//   per cycle while out_ch is ready. Inputs with at most one result run at
//   one per cycle while out_ch is ready, since a new input is taken while
//   the final result of the previous one leaves.
// Reset and stall:
//   rst_n (synchronous) clears all gates, counters and the parser and loads
//   the default configuration. When out_ch stalls, the pending result holds
//   and in_ch.ready drops until its last result is taken.
module midi_to_gate_trigger_engine
  import mgte_pkg::*;
#(
  parameter int GATE_COUNT = 8,
  parameter int CV_COUNT   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mgte_in_if.sink              in_ch,
  mgte_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [GATE_W-1:0] GATE_USED = GATE_W'((1 << GATE_COUNT) - 1);

  // Configuration registers
  logic [3:0]          listen_channel_r;
  logic [7:0]          trigger_length_r;
  logic [GATE_W-1:0]   trigger_mode_r;
  logic [GATE_W-1:0]   note_source_r;
  logic [2*CFG_W-1:0]  gate_param_r;
  logic [2*CFG_W-1:0]  cv_map_r;

  // Engine state
  logic [GATE_W-1:0]   gate_levels_r, gate_levels_nxt;
  logic [7:0]          countdown_r [GATE_COUNT];
  logic [7:0]          countdown_nxt [GATE_COUNT];
  logic [7:0]          pulse_cnt_r [GATE_COUNT];
  logic [7:0]          pulse_cnt_nxt [GATE_COUNT];
  logic                running_r, running_nxt;
  logic [1:0]          parse_count_r, parse_count_nxt;
  logic [3:0]          parse_status_r, parse_status_nxt;
  logic [6:0]          first_data_r, first_data_nxt;

  // Result register
  logic                out_valid_r;
  logic [GATE_W-1:0]   res_levels_r;
  logic [CV_COUNT-1:0] cv_mask_r, cv_mask_nxt;
  logic [CVVAL_W-1:0]  cv_value_r;

  // Decode
  logic              in_acc, out_acc, out_last;
  logic              is_tick, is_rt, is_status, is_data, msg_done;
  logic              ev_clock, ev_start, ev_cont, ev_stop;
  logic              ev_note_on, ev_note_off, ev_all_off, ev_cc_cv;
  logic [BYTE_W-1:0] rx;
  logic [BYTE_W-1:0] cv_key;
  logic [CVIDX_W-1:0] cv_first_idx;
  logic [CV_COUNT-1:0] cv_rest;

  assign rx       = in_ch.received_byte;
  assign is_tick  = in_ch.mode;
  assign is_rt    = !is_tick && (rx[7:3] == RT_PREFIX);
  assign is_status = !is_tick && rx[7] && !is_rt;
  assign is_data  = !is_tick && !rx[7];
  assign msg_done = is_data && (parse_count_r == PARSE_DATA1);

  assign ev_clock = is_rt && (rx == RT_CLOCK);
  assign ev_start = is_rt && (rx == RT_START);
  assign ev_cont  = is_rt && (rx == RT_CONTINUE);
  assign ev_stop  = is_rt && (rx == RT_STOP);

  assign ev_note_on  = msg_done && (parse_status_r == MSG_NOTE_ON) && (rx != '0);
  assign ev_note_off = msg_done && ((parse_status_r == MSG_NOTE_OFF) ||
                                    ((parse_status_r == MSG_NOTE_ON) && (rx == '0)));
  assign ev_all_off  = msg_done && (parse_status_r == MSG_CC) &&
                       ((first_data_r == CC_ALL_SOUND_OFF) ||
                        (first_data_r == CC_ALL_NOTES_OFF));
  assign ev_cc_cv    = msg_done && (parse_status_r == MSG_CC) && !ev_all_off;
  assign cv_key      = {(parse_status_r == MSG_CC), first_data_r};

  // Handshake
  assign out_last  = ((cv_mask_r & (cv_mask_r - 1'b1)) == '0);
  assign out_acc   = out_valid_r && out_ch.ready;
  assign in_ch.ready = !out_valid_r || (out_ch.ready && out_last);
  assign in_acc    = in_ch.valid && in_ch.ready;

  // Parser
  always_comb begin
    parse_count_nxt  = parse_count_r;
    parse_status_nxt = parse_status_r;
    first_data_nxt   = first_data_r;
    if (is_status) begin
      parse_count_nxt = PARSE_IDLE;
      if (((rx[7:4] == MSG_NOTE_OFF) || (rx[7:4] == MSG_NOTE_ON) || (rx[7:4] == MSG_CC)) &&
          (rx[3:0] == listen_channel_r)) begin
        parse_status_nxt = rx[7:4];
        parse_count_nxt  = PARSE_STATUS;
      end
    end else if (is_data && (parse_count_r == PARSE_STATUS)) begin
      first_data_nxt  = rx[6:0];
      parse_count_nxt = PARSE_DATA1;
    end else if (msg_done) begin
      parse_count_nxt = PARSE_STATUS;
    end
  end

  // Per-gate next state: each gate only touches its own bit and counters
  always_comb begin
    logic [7:0] p;
    logic [7:0] cnt;
    logic [7:0] cd_tog;
    logic       note_src;
    logic       trig;
    logic       need;
    gate_levels_nxt = gate_levels_r;
    running_nxt     = running_r;
    for (int i = 0; i < GATE_COUNT; i++) begin
      p        = gate_param_r[8*i +: 8];
      note_src = note_source_r[i];
      trig     = trigger_mode_r[i];
      cnt      = 8'(pulse_cnt_r[i] + 8'd1);
      cd_tog   = countdown_r[i] ^ 8'd1;
      need     = (p != '0) ? ev_start : !trig;
      countdown_nxt[i] = countdown_r[i];
      pulse_cnt_nxt[i] = pulse_cnt_r[i];
      if (is_tick) begin
        // count down a running trigger, drop it on expiry
        if (trig && (countdown_r[i] != '0)) begin
          countdown_nxt[i] = 8'(countdown_r[i] - 8'd1);
          if (countdown_r[i] == 8'd1) gate_levels_nxt[i] = 1'b0;
        end
      end else if (ev_clock) begin
        if (!note_src) begin
          if (p != '0) begin
            pulse_cnt_nxt[i] = cnt;
            if (cnt >= p) begin
              pulse_cnt_nxt[i] = '0;
              if (trig) begin
                countdown_nxt[i]   = trigger_length_r;
                gate_levels_nxt[i] = 1'b1;
              end else begin
                countdown_nxt[i]   = cd_tog;
                gate_levels_nxt[i] = (cd_tog != '0);
              end
            end
          end else if (!trig && running_r && (pulse_cnt_r[i] == '0)) begin
            pulse_cnt_nxt[i]   = 8'd1;
            gate_levels_nxt[i] = 1'b1;
          end
        end
      end else if (ev_start || ev_cont) begin
        if (!note_src) begin
          if (need) begin
            pulse_cnt_nxt[i]   = '0;
            countdown_nxt[i]   = '0;
            gate_levels_nxt[i] = 1'b0;
          end else if ((p == '0) && trig) begin
            countdown_nxt[i]   = trigger_length_r;
            gate_levels_nxt[i] = 1'b1;
          end
        end
      end else if (ev_stop) begin
        if (!note_src && !trig && (pulse_cnt_r[i] != '0)) begin
          pulse_cnt_nxt[i]   = '0;
          gate_levels_nxt[i] = 1'b0;
        end
      end else if (ev_note_off) begin
        if (note_src && !trig && (p == {1'b0, first_data_r})) gate_levels_nxt[i] = 1'b0;
      end else if (ev_all_off) begin
        if (note_src && !trig) gate_levels_nxt[i] = 1'b0;
      end else if (ev_note_on) begin
        if (note_src && (p == {1'b0, first_data_r})) begin
          gate_levels_nxt[i] = 1'b1;
          if (trig) countdown_nxt[i] = trigger_length_r;
        end
      end
    end
    if (ev_start || ev_cont) running_nxt = 1'b1;
    else if (ev_stop) running_nxt = 1'b0;
  end

  // Match CV slots against the message key
  always_comb begin
    cv_mask_nxt = '0;
    for (int i = 0; i < CV_COUNT; i++) begin
      cv_mask_nxt[i] = (ev_note_on || ev_cc_cv) && (cv_map_r[8*i +: 8] == cv_key);
    end
  end

  // Pick the lowest pending CV slot
  always_comb begin
    cv_first_idx = '0;
    for (int i = CV_COUNT - 1; i >= 0; i--) begin
      if (cv_mask_r[i]) cv_first_idx = CVIDX_W'(i);
    end
  end
  assign cv_rest = cv_mask_r & (cv_mask_r - 1'b1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_channel_r <= RST_LISTEN_CHANNEL;
      trigger_length_r <= RST_TRIGGER_LENGTH;
      trigger_mode_r   <= RST_TRIGGER_MODE;
      note_source_r    <= RST_NOTE_SOURCE;
      gate_param_r     <= {RST_GATE_PARAM_HI, RST_GATE_PARAM_LO};
      cv_map_r         <= {RST_CV_MAP_HI, RST_CV_MAP_LO};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LISTEN_CHANNEL: listen_channel_r <= cfg_data[3:0];
        CFG_TRIGGER_LENGTH: trigger_length_r <= cfg_data[7:0];
        CFG_TRIGGER_MODE:   trigger_mode_r   <= cfg_data[GATE_W-1:0];
        CFG_NOTE_SOURCE:    note_source_r    <= cfg_data[GATE_W-1:0];
        CFG_GATE_PARAM_LO:  gate_param_r[CFG_W-1:0]       <= cfg_data;
        CFG_GATE_PARAM_HI:  gate_param_r[2*CFG_W-1:CFG_W] <= cfg_data;
        CFG_CV_MAP_LO:      cv_map_r[CFG_W-1:0]           <= cfg_data;
        CFG_CV_MAP_HI:      cv_map_r[2*CFG_W-1:CFG_W]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Engine state: advance on each input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_levels_r  <= '0;
      running_r      <= 1'b0;
      parse_count_r  <= PARSE_IDLE;
      parse_status_r <= '0;
      first_data_r   <= '0;
      for (int i = 0; i < GATE_COUNT; i++) begin
        countdown_r[i] <= '0;
        pulse_cnt_r[i] <= '0;
      end
    end else if (in_acc) begin
      gate_levels_r  <= gate_levels_nxt;
      running_r      <= running_nxt;
      parse_count_r  <= parse_count_nxt;
      parse_status_r <= parse_status_nxt;
      first_data_r   <= first_data_nxt;
      for (int i = 0; i < GATE_COUNT; i++) begin
        countdown_r[i] <= countdown_nxt[i];
        pulse_cnt_r[i] <= pulse_cnt_nxt[i];
      end
    end
  end

  // Result register: load on input, drop one CV slot per result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cv_mask_r   <= '0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
      cv_mask_r   <= cv_mask_nxt;
    end else if (out_acc) begin
      out_valid_r <= !out_last;
      cv_mask_r   <= cv_rest;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_levels_r <= gate_levels_nxt;
      cv_value_r   <= rx[CVVAL_W-1:0];
    end
  end

  // Drive the result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.gate_levels = res_levels_r;
  assign out_ch.cv_valid    = (cv_mask_r != '0);
  assign out_ch.cv_index    = (cv_mask_r != '0) ? cv_first_idx : '0;
  assign out_ch.cv_value    = (cv_mask_r != '0) ? cv_value_r : '0;
  assign out_ch.last        = out_last;

  // Pending CV slots only exist while a result is shown
  a_mask_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_mask_r != '0) |-> out_valid_r)
    else $error("CV slots pending without a valid result");

  // An accepted input always yields a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted input produced no result");

  // A non-final result leaves exactly one fewer slot behind
  a_slot_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_last) |=>
      (out_valid_r && ($countones(cv_mask_r) == $past($countones(cv_mask_r)) - 1)))
    else $error("CV slot drain out of step");

  // Final result without a new input empties the result register
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last && !in_acc) |=> !out_valid_r)
    else $error("result register still valid after last result");

  // Gates beyond the configured count never go active
  a_unused_gates: assert property (@(posedge clk) disable iff (!rst_n)
    ((gate_levels_r & ~GATE_USED) == '0))
    else $error("unused gate driven active");

endmodule
